// ----- rtl/core/letterbox_nearest_scaler_rgb565_unit_assert.svh -----
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler_rgb565_unit_assert
// Assertion macros for the letterbox scaler RTL.
// ----------------------------------------------------------------------------
`ifndef LETTERBOX_NEAREST_SCALER_RGB565_UNIT_ASSERT_SVH
`define LETTERBOX_NEAREST_SCALER_RGB565_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define LNSR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lnsr check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LNSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lnsr sequence check failed");

`endif

// ----- rtl/core/lnsr_pkg.sv -----
// ----------------------------------------------------------------------------
// lnsr_pkg
// Constants, types and helpers shared by the letterbox scaler.
// ----------------------------------------------------------------------------
package lnsr_pkg;

    localparam int SRC_WIDTH   = 320;
    localparam int SRC_HEIGHT  = 240;
    localparam int STORE_DEPTH = SRC_WIDTH * SRC_HEIGHT;
    localparam int ADDR_W      = 17;
    localparam int PIX_W       = 16;
    localparam int COORD_W     = 12;
    localparam int NUM_W       = 21;   // holds (coordinate offset) * source size
    localparam int QUO_W       = 9;    // quotient stays below source size
    localparam int DIV_STEPS   = QUO_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [2:0] REG_TARGET_WIDTH  = 3'd0;
    localparam logic [2:0] REG_TARGET_HEIGHT = 3'd4;

    localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

    typedef struct packed {
        logic                  is_read;
        logic                  drawn;
        logic                  in_rect;
        logic [ADDR_W-1:0]     waddr;
        logic [PIX_W-1:0]      wpix;
    } meta_t;

    // floor(v * 255 / 31) via reciprocal multiply
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [12:0] n;
        logic [26:0] p;
        begin
            n = 13'(v) * 13'd255;
            p = 27'(n) * 27'd8457;
            widen5 = p[25:18];
        end
    endfunction

    // floor(v * 255 / 63) via reciprocal multiply
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [13:0] n;
        logic [28:0] p;
        begin
            n = 14'(v) * 14'd255;
            p = 29'(n) * 29'd16645;
            widen6 = p[27:20];
        end
    endfunction

    function automatic logic [31:0] expand565(input logic [15:0] p);
        begin
            expand565 = {8'hFF, widen5(p[4:0]), widen6(p[10:5]), widen5(p[15:11])};
        end
    endfunction

endpackage

// ----- rtl/core/letterbox_nearest_scaler_rgb565_unit.sv -----
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler_rgb565_unit
// Source frame store with aspect-preserving nearest-neighbor target readout.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// s_*     | in  | tdata: source_address, source_pixel, target_x, target_y;
//         |     | tuser: op; tlast: frame_last
// m_*     | out | tdata: rgba_pixel; tuser: drawn
// APB     | in  | target_width @0x0, target_height @0x4
//
// One item per clock while the output is not stalled; an item passes through geometry, two staged
// restoring dividers (one quotient bit per stage) and the frame memory port.
// Writes and reads share the single memory port in order, so no forwarding.
// The whole pipeline stalls while the output register holds an untaken result.
// Reset clears valid bits, frame_present and the target size registers; memory is not cleared.
// ----------------------------------------------------------------------------
`include "letterbox_nearest_scaler_rgb565_unit_assert.svh"

module letterbox_nearest_scaler_rgb565_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [16:0] source_address, [32:17] source_pixel,
                                   // [44:33] target_x, [56:45] target_y, rest 0
    input  logic        s_tuser,   // [0] op
    input  logic        s_tlast,   // frame_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] rgba_pixel
    output logic        m_tuser,   // [0] drawn
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = lnsr_pkg::COORD_W;
    localparam int NW = lnsr_pkg::NUM_W;
    localparam int QW = lnsr_pkg::QUO_W;
    localparam int DS = lnsr_pkg::DIV_STEPS;

    logic [CW-1:0] tw_reg, th_reg;
    logic          frame_present_reg;
    logic          adv;
    logic          acc;

    assign pready = 1'b1;
    assign adv    = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign acc    = s_tvalid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= '0;
            th_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == lnsr_pkg::REG_TARGET_WIDTH)
                tw_reg <= pwdata[CW-1:0];
            else if (paddr == lnsr_pkg::REG_TARGET_HEIGHT)
                th_reg <= pwdata[CW-1:0];
        end
    end

    always_comb
    begin
        if (paddr == lnsr_pkg::REG_TARGET_WIDTH)
            prdata = 32'(tw_reg);
        else if (paddr == lnsr_pkg::REG_TARGET_HEIGHT)
            prdata = 32'(th_reg);
        else
            prdata = '0;
    end

    // ---------------- geometry (input stage) ----------------
    logic [CW+1:0] tw3, th4;
    logic [31:0]   dw_prod;
    logic [CW-1:0] dw_c, dh_c, offx_c, offy_c;

    always_comb
    begin
        tw3     = 14'(tw_reg) * 14'd3;
        th4     = {th_reg, 2'b00};
        dw_prod = 32'(th4) * 32'd43691;
        if (tw3 <= th4)
        begin
            dw_c = tw_reg;
            dh_c = tw3[CW+1:2];
        end
        else
        begin
            dh_c = th_reg;
            dw_c = dw_prod[CW+16:17];
        end
        if (dw_c == '0) dw_c = CW'(1);
        if (dh_c == '0) dh_c = CW'(1);
        offx_c = CW'((tw_reg - dw_c) >> 1);
        offy_c = CW'((th_reg - dh_c) >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_present_reg <= 1'b0;
        else if (acc && s_tuser == lnsr_pkg::OP_WRITE && s_tlast)
            frame_present_reg <= 1'b1;
    end

    // stage 1
    logic             s1_valid_reg;
    lnsr_pkg::meta_t  s1_meta_reg;
    logic [CW-1:0]    s1_dw_reg, s1_dh_reg, s1_offx_reg, s1_offy_reg, s1_x_reg, s1_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_meta_reg.is_read <= (s_tuser == lnsr_pkg::OP_READ);
            s1_meta_reg.drawn   <= frame_present_reg && tw_reg != '0 && th_reg != '0;
            s1_meta_reg.in_rect <= 1'b0;
            s1_meta_reg.waddr   <= s_tdata[16:0];
            s1_meta_reg.wpix    <= s_tdata[32:17];
            s1_dw_reg   <= dw_c;
            s1_dh_reg   <= dh_c;
            s1_offx_reg <= offx_c;
            s1_offy_reg <= offy_c;
            s1_x_reg    <= s_tdata[44:33];
            s1_y_reg    <= s_tdata[56:45];
        end
    end

    // ---------------- stage 2: window test and numerators ----------------
    logic [CW:0]     endx, endy;
    logic            in_rect_c;
    logic [CW-1:0]   ux, uy;
    lnsr_pkg::meta_t s2_meta_c;

    always_comb
    begin
        endx = 13'(s1_offx_reg) + 13'(s1_dw_reg);
        endy = 13'(s1_offy_reg) + 13'(s1_dh_reg);
        in_rect_c = s1_x_reg >= s1_offx_reg && 13'(s1_x_reg) < endx &&
                    s1_y_reg >= s1_offy_reg && 13'(s1_y_reg) < endy;
        ux = s1_x_reg - s1_offx_reg;
        uy = s1_y_reg - s1_offy_reg;
        s2_meta_c         = s1_meta_reg;
        s2_meta_c.in_rect = in_rect_c;
    end

    logic            dv_valid_reg [0:DS];
    lnsr_pkg::meta_t dv_meta_reg  [0:DS];
    logic [NW-1:0]   rx_reg [0:DS];
    logic [NW-1:0]   ry_reg [0:DS];
    logic [QW-1:0]   qx_reg [0:DS];
    logic [QW-1:0]   qy_reg [0:DS];
    logic [CW-1:0]   dx_reg [0:DS];
    logic [CW-1:0]   dy_reg [0:DS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_meta_reg[0] <= s2_meta_c;
            rx_reg[0] <= (NW'(ux) << 8) + (NW'(ux) << 6);
            ry_reg[0] <= (NW'(uy) << 8) - (NW'(uy) << 4);
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            dx_reg[0] <= s1_dw_reg;
            dy_reg[0] <= s1_dh_reg;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar i = 0; i < DS; i++)
    begin : g_div
        localparam int B = DS - 1 - i;
        logic [NW:0] trx, try_;

        assign trx  = (NW+1)'(dx_reg[i]) << B;
        assign try_ = (NW+1)'(dy_reg[i]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[i+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[i+1] <= dv_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_meta_reg[i+1] <= dv_meta_reg[i];
                dx_reg[i+1]      <= dx_reg[i];
                dy_reg[i+1]      <= dy_reg[i];
                if ({1'b0, rx_reg[i]} >= trx)
                begin
                    rx_reg[i+1]    <= NW'({1'b0, rx_reg[i]} - trx);
                    qx_reg[i+1]    <= qx_reg[i] | (QW'(1) << B);
                end
                else
                begin
                    rx_reg[i+1]    <= rx_reg[i];
                    qx_reg[i+1]    <= qx_reg[i];
                end
                if ({1'b0, ry_reg[i]} >= try_)
                begin
                    ry_reg[i+1]    <= NW'({1'b0, ry_reg[i]} - try_);
                    qy_reg[i+1]    <= qy_reg[i] | (QW'(1) << B);
                end
                else
                begin
                    ry_reg[i+1]    <= ry_reg[i];
                    qy_reg[i+1]    <= qy_reg[i];
                end
            end
        end
    end

    // ---------------- address stage ----------------
    logic [QW-1:0]                sx_c, sy_c;
    logic [lnsr_pkg::ADDR_W-1:0]  raddr_c;

    always_comb
    begin
        sx_c = (qx_reg[DS] > QW'(lnsr_pkg::SRC_WIDTH - 1))
             ? QW'(lnsr_pkg::SRC_WIDTH - 1) : qx_reg[DS];
        sy_c = (qy_reg[DS] > QW'(lnsr_pkg::SRC_HEIGHT - 1))
             ? QW'(lnsr_pkg::SRC_HEIGHT - 1) : qy_reg[DS];
        raddr_c = (17'(sy_c) << 8) + (17'(sy_c) << 6) + 17'(sx_c);
    end

    logic                         am_valid_reg;
    lnsr_pkg::meta_t              am_meta_reg;
    logic [lnsr_pkg::ADDR_W-1:0]  am_raddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            am_valid_reg <= 1'b0;
        else if (adv)
            am_valid_reg <= dv_valid_reg[DS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            am_meta_reg  <= dv_meta_reg[DS];
            am_raddr_reg <= raddr_c;
        end
    end

    // ---------------- frame memory: one access per cycle unless stalled, in order ----------------
    logic [lnsr_pkg::PIX_W-1:0] frame_mem [0:lnsr_pkg::STORE_DEPTH-1];
    logic [lnsr_pkg::PIX_W-1:0] rdata_reg;
    logic                       rd_valid_reg;
    lnsr_pkg::meta_t            rd_meta_reg;

    always_ff @(posedge clk)
    begin
        if (adv && am_valid_reg)
        begin
            if (am_meta_reg.is_read)
                rdata_reg <= frame_mem[am_raddr_reg];
            else if (am_meta_reg.waddr < 17'(lnsr_pkg::STORE_DEPTH))
                frame_mem[am_meta_reg.waddr] <= am_meta_reg.wpix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else if (adv)
            rd_valid_reg <= am_valid_reg && am_meta_reg.is_read;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rd_meta_reg <= am_meta_reg;
    end

    // ---------------- output register ----------------
    logic        out_valid_reg;
    logic [31:0] out_pix_reg;
    logic        out_drawn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= rd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_drawn_reg <= rd_meta_reg.drawn;
            if (!rd_meta_reg.drawn)
                out_pix_reg <= '0;
            else if (!rd_meta_reg.in_rect)
                out_pix_reg <= lnsr_pkg::OPAQUE_BLACK;
            else
                out_pix_reg <= lnsr_pkg::expand565(rdata_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tuser  = out_drawn_reg;

    // ---------------- checks ----------------
    `LNSR_ASSERT_IMPL(a_undrawn_zero, m_tvalid && !m_tuser, m_tdata == 32'h0)
    `LNSR_ASSERT_IMPL(a_alpha_opaque, m_tvalid && m_tuser, m_tdata[31:24] == 8'hFF)
    `LNSR_ASSERT_IMPL(a_addr_range, am_valid_reg && am_meta_reg.is_read && am_meta_reg.in_rect,
        am_raddr_reg < 17'(lnsr_pkg::STORE_DEPTH))
    `LNSR_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule
